### rtl/core/cbst_pkg.sv
// shared types and constants for the complete bst level-order block
// no dependencies; used by cbst_split, complete_bst_level_order and the testbench
`default_nettype none

package cbst_pkg;

  localparam int KEY_W    = 6;            // sorted index width
  localparam int CNT_W    = 7;            // key count width, holds MAX_KEYS
  localparam int MAX_KEYS = 64;
  localparam int Q_DEPTH  = MAX_KEYS;     // range queue entries
  localparam int Q_AW     = 6;            // range queue address width

  typedef struct packed {
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] hi;
  } range_t;

  localparam int RANGE_W = $bits(range_t);

  // result of splitting one range at its root
  typedef struct packed {
    logic [KEY_W-1:0] mid;
    range_t           left;
    range_t           right;
    logic             has_left;
    logic             has_right;
  } split_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/complete_bst_level_order.sv
// top level: breadth-first (eytzinger) order of a complete binary search tree
// depends on cbst_pkg, cbst_ram, cbst_split
`default_nettype none

// A request (first_index, key_count) is taken when start is high and busy is
// low. The block then emits one result per key, in slot order 0, 1, 2, ...:
// slot, the sorted key_index that belongs there (first_index plus offset,
// wrapping at 64) and last on the final one. Each result is shown on the
// result ports for one cycle with valid high; the receiver cannot stall, so
// it must take every valid cycle. key_count above 64 is treated as 64; a
// count of zero gives no result and busy never rises. Each key passes through
// a fetch state (one queue read) and then an emit state (one split and emit),
// and the last result is on the ports in the first cycle that busy is low.
module complete_bst_level_order (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [cbst_pkg::KEY_W-1:0] first_index,
  input  wire logic [cbst_pkg::CNT_W-1:0] key_count,
  output logic                            valid,
  output logic      [cbst_pkg::KEY_W-1:0] slot,
  output logic      [cbst_pkg::KEY_W-1:0] key_index,
  output logic                            last
);

  // sequencer state
  cbst_pkg::state_t state, state_next;

  // queue pointers and counters
  logic [cbst_pkg::Q_AW-1:0]  head;
  logic [cbst_pkg::Q_AW-1:0]  tail;
  logic [cbst_pkg::CNT_W-1:0] slot_counter;
  logic [cbst_pkg::CNT_W-1:0] count;
  logic [cbst_pkg::KEY_W-1:0] first;

  // pending range (root or right child) waiting for the write port, and read bypass flag
  cbst_pkg::range_t pend;
  logic             pend_valid;
  logic             bypass;

  // ram port
  logic                           q_we;
  logic [cbst_pkg::Q_AW-1:0]      q_waddr;
  logic [cbst_pkg::RANGE_W-1:0]   q_wdata;
  logic [cbst_pkg::RANGE_W-1:0]   q_rdata;

  cbst_pkg::range_t cur;
  cbst_pkg::split_t sp;

  logic [cbst_pkg::CNT_W-1:0] sat_count;
  logic                       accept;
  logic                       is_last;

  assign busy   = (state != cbst_pkg::ST_IDLE);
  assign accept = start && !busy;

  // saturate the request count at the queue depth
  assign sat_count = (key_count > cbst_pkg::CNT_W'(cbst_pkg::MAX_KEYS))
                     ? cbst_pkg::CNT_W'(cbst_pkg::MAX_KEYS) : key_count;

  // range queue
  cbst_ram #(
    .WIDTH (cbst_pkg::RANGE_W),
    .DEPTH (cbst_pkg::Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head),
    .rdata (q_rdata)
  );

  // range under work: from the queue, or straight from the pending register
  // when it was written in the same cycle as the read
  assign cur = bypass ? pend : cbst_pkg::range_t'(q_rdata);

  cbst_split u_split (
    .rng (cur),
    .res (sp)
  );

  assign is_last = (slot_counter + cbst_pkg::CNT_W'(1) == count);

  // write port: fetch pushes the pending range (root or right child), emit pushes the left one
  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail;
    q_wdata = pend;
    case (state)
      cbst_pkg::ST_FETCH: begin
        q_we    = pend_valid;
        q_wdata = pend;
      end
      cbst_pkg::ST_EMIT: begin
        q_we    = sp.has_left;
        q_wdata = sp.left;
      end
      default: begin
        q_we = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cbst_pkg::ST_IDLE: begin
        if (accept && (sat_count != '0)) begin
          state_next = cbst_pkg::ST_FETCH;
        end
      end
      cbst_pkg::ST_FETCH: begin
        state_next = cbst_pkg::ST_EMIT;
      end
      cbst_pkg::ST_EMIT: begin
        state_next = is_last ? cbst_pkg::ST_IDLE : cbst_pkg::ST_FETCH;
      end
      default: begin
        state_next = cbst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      slot_counter <= '0;
      pend_valid   <= 1'b0;
      bypass       <= 1'b0;
      valid        <= 1'b0;
    end else begin
      valid <= (state == cbst_pkg::ST_EMIT);
      case (state)
        cbst_pkg::ST_IDLE: begin
          if (accept) begin
            // root range seeds the pending register, queue starts empty
            head         <= '0;
            tail         <= '0;
            slot_counter <= '0;
            pend_valid   <= (sat_count != '0);
          end
        end
        cbst_pkg::ST_FETCH: begin
          head <= head + cbst_pkg::Q_AW'(1);
          if (pend_valid) begin
            tail   <= tail + cbst_pkg::Q_AW'(1);
            bypass <= (head == tail);
          end else begin
            bypass <= 1'b0;
          end
          pend_valid <= 1'b0;
        end
        cbst_pkg::ST_EMIT: begin
          if (sp.has_left) begin
            tail <= tail + cbst_pkg::Q_AW'(1);
          end
          pend_valid   <= sp.has_right;
          slot_counter <= slot_counter + cbst_pkg::CNT_W'(1);
        end
        default: begin
          pend_valid <= 1'b0;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      cbst_pkg::ST_IDLE: begin
        if (accept) begin
          first   <= first_index;
          count   <= sat_count;
          pend.lo <= '0;
          pend.hi <= cbst_pkg::KEY_W'(sat_count - cbst_pkg::CNT_W'(1));
        end
      end
      cbst_pkg::ST_EMIT: begin
        pend      <= sp.right;
        slot      <= slot_counter[cbst_pkg::KEY_W-1:0];
        key_index <= first + sp.mid;
        last      <= is_last;
      end
      default: begin
        pend <= pend;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // every result comes from one emit step
  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(state == cbst_pkg::ST_EMIT))
    else $error("result without emit step");

  // the block goes idle exactly as the final result shows
  a_idle_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (valid && last))
    else $error("busy dropped without last result");

  // after the final result the block is ready again
  a_last_then_idle: assert property (@(posedge clk) disable iff (rst)
    (valid && last) |-> !busy)
    else $error("still busy after last result");

  // the emit step always sees a non-empty range
  a_range_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == cbst_pkg::ST_EMIT) |-> (cur.lo <= cur.hi))
    else $error("empty range popped");
`endif

endmodule

`default_nettype wire

### rtl/core/cbst_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cbst_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/cbst_split.sv
// root picker: splits a range so the left subtree has complete-tree size
// depends on cbst_pkg
`default_nettype none

module cbst_split (
  input  wire cbst_pkg::range_t rng,
  output cbst_pkg::split_t      res
);

  logic [cbst_pkg::CNT_W-1:0] n;
  logic [cbst_pkg::CNT_W-1:0] p;
  logic [cbst_pkg::CNT_W-1:0] half;
  logic [cbst_pkg::CNT_W-1:0] bottom;
  logic [cbst_pkg::CNT_W-1:0] lsize;
  logic [cbst_pkg::KEY_W-1:0] mid;

  always_comb begin
    n = cbst_pkg::CNT_W'(rng.hi) - cbst_pkg::CNT_W'(rng.lo) + cbst_pkg::CNT_W'(1);
    // highest power of two not above n
    p = cbst_pkg::CNT_W'(1);
    for (int i = 0; i < cbst_pkg::CNT_W; i++) begin
      if (n[i]) begin
        p = cbst_pkg::CNT_W'(1) << i;
      end
    end
    half   = p >> 1;
    bottom = n - p + cbst_pkg::CNT_W'(1);
    if (n < cbst_pkg::CNT_W'(2)) begin
      lsize = '0;
    end else if (bottom < half) begin
      lsize = half - cbst_pkg::CNT_W'(1) + bottom;
    end else begin
      lsize = half - cbst_pkg::CNT_W'(1) + half;
    end
    mid = rng.lo + lsize[cbst_pkg::KEY_W-1:0];

    res.mid       = mid;
    res.has_left  = (mid > rng.lo);
    res.has_right = (mid < rng.hi);
    res.left.lo   = rng.lo;
    res.left.hi   = mid - cbst_pkg::KEY_W'(1);
    res.right.lo  = mid + cbst_pkg::KEY_W'(1);
    res.right.hi  = rng.hi;
  end

endmodule

`default_nettype wire

### verif/tb_complete_bst_level_order.sv
// self-checking testbench for complete_bst_level_order (eytzinger layout order)
// depends on cbst_pkg and the rtl under rtl/core; drives requests, predicts
// every slot placement and checks each strobed result in order
`default_nettype none

module tb_complete_bst_level_order;
  timeunit 1ns;
  timeprecision 1ps;

  import cbst_pkg::*;

  // one expected placement: which sorted key lands in which breadth-first slot
  typedef struct packed {
    logic [KEY_W-1:0] slot;
    logic [KEY_W-1:0] key_index;
    logic             last;
  } placement_t;

  // directed request row; typed rows carry their placements written out
  typedef struct {
    logic [KEY_W-1:0] first;
    logic [CNT_W-1:0] count;
    bit               typed;
    int               n_typed;
    logic [KEY_W-1:0] k0;
    logic [KEY_W-1:0] k1;
  } request_row_t;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 75;
  localparam int MAX_REPORTS  = 10;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [KEY_W-1:0] first_index;
  logic [CNT_W-1:0] key_count;
  logic             valid;
  logic [KEY_W-1:0] slot;
  logic [KEY_W-1:0] key_index;
  logic             last;

  placement_t pending_placements[$];
  int         fail_count;

  // short rows: zero count gives nothing, one key is its own root, two keys put
  // the larger one at the root with the smaller as its left child
  request_row_t directed_rows [NUM_DIRECTED] = '{
    '{6'd0,  7'd0,   1'b1, 0, 6'd0,  6'd0},   // zero count, all bits low
    '{6'd63, 7'd0,   1'b1, 0, 6'd0,  6'd0},
    '{6'd0,  7'd1,   1'b1, 1, 6'd0,  6'd0},
    '{6'd63, 7'd1,   1'b1, 1, 6'd63, 6'd0},
    '{6'd10, 7'd2,   1'b1, 2, 6'd11, 6'd10},
    '{6'd63, 7'd2,   1'b1, 2, 6'd0,  6'd63},  // root wraps past index 63
    '{6'd5,  7'd3,   1'b0, 0, 6'd0,  6'd0},
    '{6'd5,  7'd4,   1'b0, 0, 6'd0,  6'd0},
    '{6'd5,  7'd5,   1'b0, 0, 6'd0,  6'd0},
    '{6'd5,  7'd6,   1'b0, 0, 6'd0,  6'd0},
    '{6'd5,  7'd7,   1'b0, 0, 6'd0,  6'd0},   // perfect tree
    '{6'd20, 7'd8,   1'b0, 0, 6'd0,  6'd0},
    '{6'd20, 7'd15,  1'b0, 0, 6'd0,  6'd0},
    '{6'd20, 7'd16,  1'b0, 0, 6'd0,  6'd0},
    '{6'd20, 7'd17,  1'b0, 0, 6'd0,  6'd0},
    '{6'd0,  7'd31,  1'b0, 0, 6'd0,  6'd0},
    '{6'd0,  7'd32,  1'b0, 0, 6'd0,  6'd0},
    '{6'd0,  7'd33,  1'b0, 0, 6'd0,  6'd0},
    '{6'd0,  7'd63,  1'b0, 0, 6'd0,  6'd0},
    '{6'd0,  7'd64,  1'b0, 0, 6'd0,  6'd0},   // full capacity
    '{6'd63, 7'd64,  1'b0, 0, 6'd0,  6'd0},   // full capacity, wrapping keys
    '{6'd1,  7'd65,  1'b0, 0, 6'd0,  6'd0},   // saturated count
    '{6'd32, 7'd100, 1'b0, 0, 6'd0,  6'd0},
    '{6'd63, 7'd127, 1'b0, 0, 6'd0,  6'd0},   // all bits high
    '{6'd42, 7'd127, 1'b0, 0, 6'd0,  6'd0}
  };

  complete_bst_level_order u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .first_index (first_index),
    .key_count   (key_count),
    .valid       (valid),
    .slot        (slot),
    .key_index   (key_index),
    .last        (last)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // size of the left subtree of a complete tree of n nodes
  function automatic int left_branch_keys(input int n);
    int pow2;
    int half;
    int bottom;
    if (n < 2) return 0;
    pow2 = 1;
    while (pow2 * 2 <= n) pow2 = pow2 * 2;
    half   = pow2 / 2;
    bottom = n - (pow2 - 1);
    return (half - 1) + ((bottom < half) ? bottom : half);
  endfunction

  // breadth-first walk over index ranges, appending one placement per key
  function automatic void predict_layout(input logic [KEY_W-1:0] base,
                                         input logic [CNT_W-1:0] count_in);
    range_t           ranges [MAX_KEYS];
    range_t           cur;
    int               head;
    int               tail;
    logic [KEY_W-1:0] root;
    logic [CNT_W-1:0] keys;
    logic [CNT_W-1:0] placed;
    placement_t       p;
    keys = (count_in > MAX_KEYS) ? CNT_W'(MAX_KEYS) : count_in;
    if (keys == 0) return;
    ranges[0].lo = '0;
    ranges[0].hi = KEY_W'(keys - 1);
    head   = 0;
    tail   = 1;
    placed = '0;
    while (head < tail) begin
      cur  = ranges[head];
      head = head + 1;
      root = cur.lo + KEY_W'(left_branch_keys(int'(cur.hi) - int'(cur.lo) + 1));
      p.slot      = placed[KEY_W-1:0];
      p.key_index = base + root;
      p.last      = (placed + 1'b1 == keys);
      pending_placements.push_back(p);
      placed = placed + 1'b1;
      if (root > cur.lo) begin
        ranges[tail].lo = cur.lo;
        ranges[tail].hi = root - 1'b1;
        tail = tail + 1;
      end
      if (root < cur.hi) begin
        ranges[tail].lo = root + 1'b1;
        ranges[tail].hi = cur.hi;
        tail = tail + 1;
      end
    end
  endfunction

  function automatic void record_failure(input string msg);
    fail_count = fail_count + 1;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // holds the request on the pins until the block takes it; returns at the
  // accepting rising edge, start still high
  task automatic issue_request(input logic [KEY_W-1:0] fi, input logic [CNT_W-1:0] kc);
    first_index <= fi;
    key_count   <= kc;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // random request: half take any count up to 64, some short trees, some zero
  // counts and some above capacity
  task automatic issue_random_request();
    logic [KEY_W-1:0] fi;
    logic [CNT_W-1:0] kc;
    int               pick;
    fi   = KEY_W'($urandom_range(0, 63));
    pick = $urandom_range(0, 9);
    if (pick == 0) kc = '0;
    else if (pick == 1) kc = CNT_W'($urandom_range(65, 127));
    else if (pick <= 4) kc = CNT_W'($urandom_range(1, 8));
    else kc = CNT_W'($urandom_range(1, 64));
    issue_request(fi, kc);
    predict_layout(fi, kc);
    @(negedge clk);
  endtask

  // result checker: the receiver cannot stall, so every strobe is taken
  always @(posedge clk) begin
    placement_t want;
    if (!rst && valid) begin
      if (pending_placements.size() == 0) begin
        record_failure($sformatf("unexpected result slot=%0d key_index=%0d last=%0b",
                                 slot, key_index, last));
      end else begin
        want = pending_placements.pop_front();
        if (slot !== want.slot || key_index !== want.key_index || last !== want.last) begin
          record_failure($sformatf(
            "mismatch: expected slot=%0d key_index=%0d last=%0b, got slot=%0d key_index=%0d last=%0b",
            want.slot, want.key_index, want.last, slot, key_index, last));
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int         sent;
    int         burst;
    int         waited;
    placement_t p;
    fail_count  = 0;
    rst         = 1'b1;
    start       = 1'b0;
    first_index = '0;
    key_count   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows back to back, no gaps between requests
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      issue_request(directed_rows[i].first, directed_rows[i].count);
      if (directed_rows[i].typed) begin
        for (int k = 0; k < directed_rows[i].n_typed; k++) begin
          p.slot      = KEY_W'(k);
          p.key_index = (k == 0) ? directed_rows[i].k0 : directed_rows[i].k1;
          p.last      = (k == directed_rows[i].n_typed - 1);
          pending_placements.push_back(p);
        end
      end else begin
        predict_layout(directed_rows[i].first, directed_rows[i].count);
      end
      @(negedge clk);
    end

    // random bursts; start only drops when a gap follows, so gaps land at varied
    // points early in a running layout, or after a short one has ended
    sent = 0;
    while (sent < NUM_RANDOM) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst; b++) begin
        issue_random_request();
        sent = sent + 1;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    start <= 1'b0;

    // drain: at most one full layout plus slack, then a short settle
    waited = 0;
    while (pending_placements.size() != 0 && waited < 4 * MAX_KEYS + 16) begin
      @(posedge clk);
      waited = waited + 1;
    end
    repeat (10) @(posedge clk);
    if (pending_placements.size() != 0) begin
      record_failure($sformatf("%0d expected results never arrived",
                               pending_placements.size()));
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog: 2 ms is many times the slowest good run of roughly 100 requests plus gaps
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
